// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by prga_datapath.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held.
`define PRGA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define PRGA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/prga_pkg.sv =====
package prga_pkg;

  localparam int ID_W   = 3;
  localparam int KIND_W = 2;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] requester_id;
    logic [ID_W-1:0] left_resource;
    logic [ID_W-1:0] right_resource;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [ID_W-1:0]   target_id;
    logic              last_result;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;
    logic load_rel;
    logic scan;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/prga_ctrl.sv =====
module prga_ctrl import prga_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       opcode,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_REQUEST) begin
            cmd.load_req = 1'b1;
          end else begin
            cmd.load_rel = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        busy     = 1'b1;
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/prga_datapath.sv =====
`include "assert_macros.svh"

module prga_datapath import prga_pkg::*; #(
  parameter int NUM_MEMBERS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  in_item_t   in_item,
  output dp_status_t status,
  output logic       out_strobe,
  output out_item_t  out_item
);

  localparam int IW = $clog2(NUM_MEMBERS);
  localparam int LW = $clog2(NUM_MEMBERS + 1);
  localparam int RW = (LW > ID_W) ? LW : ID_W;

  logic [NUM_MEMBERS-1:0] free_r, free_nxt;
  logic [ID_W-1:0]        queue_r [NUM_MEMBERS];
  logic [ID_W-1:0]        queue_nxt [NUM_MEMBERS];
  logic [LW-1:0]          len_r, len_nxt;
  logic [LW-1:0]          idx_r, idx_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]        pend_id_r, pend_id_nxt;
  logic                   strobe_r, strobe_nxt;
  out_item_t              item_r, item_nxt;

  logic [NUM_MEMBERS-1:0] req_l_mask, req_r_mask, rel_mask;
  logic [NUM_MEMBERS-1:0] pair_a_mask, pair_b_mask;
  logic                   req_fit, scan_done, scan_hit;
  logic [ID_W-1:0]        waiter;
  logic [RW-1:0]          pair_lo;

  // One-hot bit for a resource number; out-of-range numbers give no bit.
  function automatic logic [NUM_MEMBERS-1:0] res_mask(input logic [RW-1:0] r);
    logic [NUM_MEMBERS-1:0] m;
    for (int k = 0; k < NUM_MEMBERS; k++) begin
      m[k] = (r == RW'(k + 1));
    end
    return m;
  endfunction

  always_comb begin
    req_l_mask = res_mask(RW'(in_item.left_resource));
    req_r_mask = res_mask(RW'(in_item.right_resource));
    rel_mask   = req_l_mask | req_r_mask;
    req_fit    = (|(req_l_mask & free_r)) && (|(req_r_mask & free_r));

    scan_done = (idx_r >= len_r);
    waiter    = queue_r[idx_r[IW-1:0]];
    // Ring neighbor below the waiter, wrapping from the first to the last.
    pair_lo     = (waiter > ID_W'(1)) ? (RW'(waiter) - RW'(1)) : RW'(NUM_MEMBERS);
    pair_a_mask = res_mask(RW'(waiter));
    pair_b_mask = res_mask(pair_lo);
    scan_hit    = (|(pair_a_mask & free_r)) && (|(pair_b_mask & free_r));
  end

  assign status.scan_done = scan_done;

  always_comb begin
    free_nxt       = free_r;
    queue_nxt      = queue_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    strobe_nxt     = 1'b0;
    item_nxt       = item_r;

    priority if (cmd.load_req) begin
      strobe_nxt           = 1'b1;
      item_nxt.target_id   = in_item.requester_id;
      item_nxt.last_result = 1'b1;
      if (req_fit) begin
        free_nxt             = free_r & ~rel_mask;
        item_nxt.result_kind = KIND_GRANT;
      end else if (len_r < LW'(NUM_MEMBERS)) begin
        for (int k = 0; k < NUM_MEMBERS; k++) begin
          if (len_r == LW'(k)) begin
            queue_nxt[k] = in_item.requester_id;
          end
        end
        len_nxt              = len_r + LW'(1);
        item_nxt.result_kind = KIND_QUEUED;
      end else begin
        item_nxt.result_kind = KIND_DROPPED;
      end
    end else if (cmd.load_rel) begin
      free_nxt       = free_r | rel_mask;
      idx_nxt        = '0;
      pend_valid_nxt = 1'b0;
    end else if (cmd.scan) begin
      if (scan_done) begin
        // Flush the held grant as the final beat of this release.
        if (pend_valid_r) begin
          strobe_nxt           = 1'b1;
          item_nxt.result_kind = KIND_GRANT;
          item_nxt.target_id   = pend_id_r;
          item_nxt.last_result = 1'b1;
        end
        pend_valid_nxt = 1'b0;
      end else if (scan_hit) begin
        free_nxt = free_r & ~(pair_a_mask | pair_b_mask);
        // Close the gap; the index stays so the next waiter is not skipped.
        for (int k = 0; k < NUM_MEMBERS; k++) begin
          if (LW'(k) >= idx_r) begin
            queue_nxt[k] = (k + 1 < NUM_MEMBERS) ? queue_r[(k + 1) % NUM_MEMBERS] : '0;
          end
        end
        len_nxt = len_r - LW'(1);
        if (pend_valid_r) begin
          strobe_nxt           = 1'b1;
          item_nxt.result_kind = KIND_GRANT;
          item_nxt.target_id   = pend_id_r;
          item_nxt.last_result = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_id_nxt    = waiter;
      end else begin
        idx_nxt = idx_r + LW'(1);
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r       <= '1;
      queue_r      <= '{default: '0};
      len_r        <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      free_r       <= free_nxt;
      queue_r      <= queue_nxt;
      len_r        <= len_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    item_r    <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

  `PRGA_ASSERT(a_hit_shrinks, clk, rst_n, (cmd.scan && !scan_done && scan_hit) |=> (len_r == $past(len_r) - LW'(1)), "scan hit did not remove a waiter")
  `PRGA_ASSERT(a_done_flushes, clk, rst_n, (cmd.scan && scan_done) |=> !pend_valid_r, "held grant survived end of scan")
  `PRGA_ASSERT_NEVER(a_queued_last, clk, rst_n, strobe_r && (item_r.result_kind != KIND_GRANT) && !item_r.last_result, "queued or dropped beat not marked last")
  `PRGA_ASSERT_NEVER(a_len_bound, clk, rst_n, (len_r > LW'(NUM_MEMBERS)) || (idx_r > len_r), "queue length or scan index out of bounds")

endmodule

// ===== hw/rtl/paired_resource_grant_arbiter.sv =====
// Coordinator for a ring of NUM_MEMBERS requesters, each needing resources k and k-1 (the
// first wraps to the last). A command is taken when start is high and busy is low. A request
// leaves busy low: one beat appears on out_item in the next cycle, marked by out_strobe, with
// kind grant, queued or dropped (queue full). A release holds busy high while the wait queue
// is scanned one entry per cycle. Each waiter whose pair is free is granted in queue order; a
// grant beat is held until the next grant or the end of the scan shows whether it is the
// final one, leaves in the cycle after that, and the final one carries last_result.
// A release that serves nobody gives no beat. Beats cannot be held off by the receiver.
module paired_resource_grant_arbiter import prga_pkg::*; #(
  parameter int NUM_MEMBERS = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  prga_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  prga_datapath #(
    .NUM_MEMBERS (NUM_MEMBERS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prga_pkg::*;

  localparam int     MEMBERS      = 5;
  localparam int     RANDOM_ITEMS = 236;
  localparam int     SETTLE       = MEMBERS + 6;
  localparam longint CYCLE_LIMIT  = 20000;
  localparam int     IN_W         = $bits(in_item_t);

  typedef struct packed {
    in_item_t  item;
    logic      pinned;
    out_item_t exp;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // Typed expectation travelling with the beat that is being offered.
  logic      pin_valid;
  out_item_t pin_exp;

  // Shadow of the coordinator.
  logic [MEMBERS-1:0] free_map = '1;
  logic [ID_W-1:0]    waiters[$];
  out_item_t          beats_due[$];

  stim_row_t directed[$];
  out_item_t due;
  int        mismatches  = 0;
  longint    cycle_count = 0;

  paired_resource_grant_arbiter #(.NUM_MEMBERS(MEMBERS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int ring_prev(int k);
    return (k > 1) ? k - 1 : MEMBERS;
  endfunction

  function automatic bit res_free(int r);
    return r >= 1 && r <= MEMBERS && free_map[r-1];
  endfunction

  function automatic void set_res(int r, logic v);
    if (r >= 1 && r <= MEMBERS) free_map[r-1] = v;
  endfunction

  // Advance the shadow by one command and queue the beats it causes.
  function automatic void arbitrate(in_item_t it);
    out_item_t       beat;
    logic [ID_W-1:0] w;
    int              i;
    bit              held;
    beat = '0;
    held = 1'b0;
    if (it.opcode == OP_REQUEST) begin
      beat.target_id   = it.requester_id;
      beat.last_result = 1'b1;
      if (res_free(int'(it.left_resource)) && res_free(int'(it.right_resource))) begin
        set_res(int'(it.left_resource), 1'b0);
        set_res(int'(it.right_resource), 1'b0);
        beat.result_kind = KIND_GRANT;
      end else if (waiters.size() < MEMBERS) begin
        waiters.push_back(it.requester_id);
        beat.result_kind = KIND_QUEUED;
      end else begin
        beat.result_kind = KIND_DROPPED;
      end
      beats_due.push_back(beat);
    end else begin
      set_res(int'(it.left_resource), 1'b1);
      set_res(int'(it.right_resource), 1'b1);
      i = 0;
      // Stay at the same slot after a removal.
      while (i < waiters.size()) begin
        w = waiters[i];
        if (res_free(int'(w)) && res_free(ring_prev(int'(w)))) begin
          set_res(int'(w), 1'b0);
          set_res(ring_prev(int'(w)), 1'b0);
          waiters.delete(i);
          if (held) beats_due.push_back(beat);
          beat.result_kind = KIND_GRANT;
          beat.target_id   = w;
          beat.last_result = 1'b0;
          held = 1'b1;
        end else begin
          i++;
        end
      end
      // Mark the final grant of this release.
      if (held) begin
        beat.last_result = 1'b1;
        beats_due.push_back(beat);
      end
    end
  endfunction

  function automatic stim_row_t req(int id, int l, int r, logic [KIND_W-1:0] kind);
    stim_row_t row;
    row.item.opcode         = OP_REQUEST;
    row.item.requester_id   = ID_W'(id);
    row.item.left_resource  = ID_W'(l);
    row.item.right_resource = ID_W'(r);
    row.pinned              = 1'b1;
    row.exp.result_kind     = kind;
    row.exp.target_id       = ID_W'(id);
    row.exp.last_result     = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t rel(int id, int l, int r);
    stim_row_t row;
    row                     = '0;
    row.item.opcode         = OP_RELEASE;
    row.item.requester_id   = ID_W'(id);
    row.item.left_resource  = ID_W'(l);
    row.item.right_resource = ID_W'(r);
    return row;
  endfunction

  // Mostly ring-pair requests and releases of held pairs, with some noise.
  function automatic in_item_t next_item();
    in_item_t it;
    int       k;
    int       pick;
    int       t;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(1, MEMBERS);
    it   = '0;
    if (pick < 12) begin
      it = IN_W'($urandom_range(0, 1023));
      // Keep out-of-range waiters from clogging the queue for good.
      if (it.opcode == OP_REQUEST && (it.requester_id < 1 || it.requester_id > MEMBERS) &&
          !(res_free(int'(it.left_resource)) && res_free(int'(it.right_resource))))
        it.requester_id = ID_W'(k);
    end else begin
      if (pick < 56) begin
        it.opcode = OP_REQUEST;
      end else begin
        it.opcode = OP_RELEASE;
        for (t = 0; t < MEMBERS && (res_free(k) || res_free(ring_prev(k))); t++)
          k = k % MEMBERS + 1;
      end
      it.requester_id = ID_W'(k);
      if ($urandom_range(0, 1)) begin
        it.left_resource  = ID_W'(k);
        it.right_resource = ID_W'(ring_prev(k));
      end else begin
        it.left_resource  = ID_W'(ring_prev(k));
        it.right_resource = ID_W'(k);
      end
    end
    return it;
  endfunction

  task automatic report(string what, out_item_t got, out_item_t want);
    mismatches++;
    $display("mismatch at cycle %0d: %s, got kind=%0d id=%0d last=%0d, want kind=%0d id=%0d last=%0d",
             cycle_count, what, got.result_kind, got.target_id, got.last_result,
             want.result_kind, want.target_id, want.last_result);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (beats_due.size() == 0) begin
          report("beat with nothing due", out_item, '0);
        end else begin
          due = beats_due.pop_front();
          if (out_item.result_kind !== due.result_kind) report("result_kind", out_item, due);
          if (out_item.target_id !== due.target_id) report("target_id", out_item, due);
          if (out_item.last_result !== due.last_result) report("last_result", out_item, due);
        end
      end else if (out_strobe !== 1'b0) begin
        report("unknown strobe", out_item, '0);
      end
      if (start === 1'b1 && busy === 1'b0) begin
        arbitrate(in_item);
        if (pin_valid) begin
          void'(beats_due.pop_back());
          beats_due.push_back(pin_exp);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic present(in_item_t it, logic pin, out_item_t exp);
    start     <= 1'b1;
    in_item   <= it;
    pin_valid <= pin;
    pin_exp   <= exp;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Hold the sender until every expected beat has arrived.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (beats_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int burst;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    pin_valid = 1'b0;
    pin_exp   = '0;
    burst     = 0;

    directed.push_back(req(1, 1, 5, KIND_GRANT));
    directed.push_back(req(2, 2, 1, KIND_QUEUED));
    directed.push_back(req(3, 3, 2, KIND_GRANT));
    directed.push_back(req(5, 5, 4, KIND_QUEUED));
    directed.push_back(req(0, 0, 0, KIND_QUEUED));
    directed.push_back(req(4, 7, 6, KIND_QUEUED));
    directed.push_back(req(7, 4, 4, KIND_GRANT));
    directed.push_back(req(2, 2, 1, KIND_QUEUED));
    directed.push_back(req(1, 1, 5, KIND_DROPPED));
    directed.push_back(req(6, 6, 0, KIND_DROPPED));
    directed.push_back(rel(1, 1, 5));
    directed.push_back(rel(7, 4, 4));
    directed.push_back(rel(3, 3, 2));
    directed.push_back(rel(0, 0, 7));
    directed.push_back(rel(5, 5, 4));
    directed.push_back(rel(2, 1, 2));
    directed.push_back(rel(4, 4, 3));
    directed.push_back(rel(2, 2, 1));
    directed.push_back(req(1, 1, 3, KIND_GRANT));
    directed.push_back(req(1, 1, 5, KIND_QUEUED));
    directed.push_back(req(3, 3, 2, KIND_QUEUED));
    directed.push_back(rel(1, 1, 3));
    directed.push_back(rel(1, 1, 5));
    directed.push_back(rel(3, 3, 2));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      present(directed[k].item, directed[k].pinned, directed[k].exp);
      hold_off($urandom_range(0, 2));
    end
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain();
      if (burst == 0) begin
        hold_off($urandom_range(1, 8));
        burst = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 10);
      end
      present(next_item(), 1'b0, '0);
      burst--;
    end
    drain();
    hold_off(SETTLE);

    if (mismatches == 0 && beats_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
